// File: rtl/core/assert_macros.svh
// Assertion macros used by the memory type range allocator top level.
// Expects clk and rst (synchronous, active high) in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/mtra_pkg.sv
// Shared types, constants and helpers for the memory type range allocator.
// No dependencies; imported by every module of the block.
package mtra_pkg;

  localparam int ADDR_W          = 52;
  localparam int SIZE_W          = 53;
  localparam int SUM_W           = 54;
  localparam int TYPE_W          = 3;
  localparam int SLOT_W          = 3;
  localparam int WORD_W          = 64;
  localparam int PAGE_W          = 12;
  localparam int HI_W            = ADDR_W - PAGE_W;
  localparam int PAB_W           = 6;
  localparam int COUNT_W         = 4;
  localparam int CFG_ADDR_W      = 2;
  localparam int CFG_DATA_W      = 6;
  localparam int IN_W            = 112;
  localparam int OUT_W           = 136;
  localparam int VALID_BIT       = 11;
  localparam int MIN_ADDR_BITS   = 32;
  localparam int MAX_ADDR_BITS   = 52;
  localparam int DEF_MAX_ENTRIES = 8;

  localparam logic [PAB_W-1:0]   RST_PHYS_BITS   = PAB_W'(36);
  localparam logic [COUNT_W-1:0] RST_ENTRY_COUNT = COUNT_W'(8);
  localparam logic [SUM_W-1:0]   WRAP_LIMIT      = SUM_W'(1) << MAX_ADDR_BITS;

  typedef enum logic [3:0] {
    ST_OK             = 4'd0,
    ST_UNSUPPORTED    = 4'd1,
    ST_MISALIGNED     = 4'd2,
    ST_WRAPS          = 4'd3,
    ST_NOT_POW2       = 4'd4,
    ST_UNALIGNED_BASE = 4'd5,
    ST_BAD_NAME       = 4'd6,
    ST_UNKNOWN_TYPE   = 4'd7,
    ST_WC_UNSUPPORTED = 4'd8,
    ST_OVERLAP        = 4'd9,
    ST_NO_SLOT        = 4'd10
  } status_t;

  typedef enum logic [TYPE_W-1:0] {
    MT_UC       = 3'd0,
    MT_WC       = 3'd1,
    MT_UNK2     = 3'd2,
    MT_UNK3     = 3'd3,
    MT_WT       = 3'd4,
    MT_WP       = 3'd5,
    MT_WB       = 3'd6,
    MT_BAD_NAME = 3'd7
  } mem_type_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_RANGE_SUPPORT  = 2'd0,
    CFG_PHYS_ADDR_BITS = 2'd1,
    CFG_ENTRY_COUNT    = 2'd2,
    CFG_WC_SUPPORT     = 2'd3
  } cfg_index_t;

  // Stored entry: address bits above the page offset of base and mask words.
  typedef struct packed {
    logic [HI_W-1:0] base_hi;
    logic [HI_W-1:0] mask_hi;
  } entry_t;

  typedef struct packed {
    logic    valid;
    status_t status;
  } chk_t;

  // Address mask of the saturated physical address width.
  function automatic logic [ADDR_W-1:0] phys_mask(input logic [PAB_W-1:0] bits);
    logic [PAB_W-1:0]  w;
    logic [ADDR_W-1:0] m;
    w = bits;
    if (w < PAB_W'(MIN_ADDR_BITS)) w = PAB_W'(MIN_ADDR_BITS);
    if (w > PAB_W'(MAX_ADDR_BITS)) w = PAB_W'(MAX_ADDR_BITS);
    for (int j = 0; j < ADDR_W; j++) begin
      m[j] = (PAB_W'(j) < w);
    end
    return m;
  endfunction

endpackage

// File: rtl/core/mtra_check.sv
// Two-stage request checker: range support, alignment, wrap, size and type rules in priority order.
// Depends on mtra_pkg.
module mtra_check import mtra_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ADDR_W-1:0] base,
  input  logic [SIZE_W-1:0] size,
  input  logic [TYPE_W-1:0] mtype,
  input  logic              range_support,
  input  logic              wc_support,
  output chk_t              result
);

  logic              s1_v;
  logic [ADDR_W-1:0] s1_base;
  logic [SIZE_W-1:0] s1_size;
  logic [SIZE_W-1:0] s1_size_m1;
  logic [TYPE_W-1:0] s1_type;
  logic              s1_unsup;
  logic              s1_misal;
  logic              s1_wrap;
  logic              pow2;
  logic              unaligned;
  status_t           status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v         <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      s1_v         <= start;
      result.valid <= s1_v;
    end
    result.status <= status_next;
  end

  // Stage one: the wide adds and the early flags.
  always_ff @(posedge clk) begin
    if (start) begin
      s1_base    <= base;
      s1_size    <= size;
      s1_size_m1 <= size - SIZE_W'(1);
      s1_type    <= mtype;
      s1_unsup   <= !range_support;
      s1_misal   <= (base[PAGE_W-1:0] != '0) || (size[PAGE_W-1:0] != '0) || (size == '0);
      s1_wrap    <= (SUM_W'(base) + SUM_W'(size)) > WRAP_LIMIT;
    end
  end

  assign pow2      = (s1_size & s1_size_m1) == '0;
  assign unaligned = (s1_base & s1_size_m1[ADDR_W-1:0]) != '0;

  // Stage two: resolve in check order.
  always_comb begin
    if (s1_unsup)                                 status_next = ST_UNSUPPORTED;
    else if (s1_misal)                            status_next = ST_MISALIGNED;
    else if (s1_wrap)                             status_next = ST_WRAPS;
    else if (!pow2)                               status_next = ST_NOT_POW2;
    else if (unaligned)                           status_next = ST_UNALIGNED_BASE;
    else if (s1_type == MT_BAD_NAME)              status_next = ST_BAD_NAME;
    else if (s1_type inside {MT_UNK2, MT_UNK3})   status_next = ST_UNKNOWN_TYPE;
    else if (s1_type == MT_WC && !wc_support)     status_next = ST_WC_UNSUPPORTED;
    else                                          status_next = ST_OK;
  end

endmodule

// File: rtl/core/mtra_table.sv
// Variable range table: synchronous memory of entries with a registered read.
// Per-entry valid flags live in flip-flops cleared by reset. Depends on mtra_pkg.
module mtra_table import mtra_pkg::*; #(
  parameter  int MAX_ENTRIES = DEF_MAX_ENTRIES,
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data,
  output logic             rd_valid,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data
);

  entry_t                 mem [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // An entry that was never written reads as invalid; its data is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

endmodule

// File: rtl/core/memory_type_range_allocator_top.sv
// Memory type range allocator. Each request (base, size, type) is first checked by
// mtra_check, then the variable range table is scanned from entry 0 through its single
// read port, one entry per cycle with a two-stage decode pipeline behind it, and on
// success one entry is written and the encoded base and mask words are returned.
// One request is handled at a time, and a new request is taken only once the result
// of the last has been issued; a scan stops early at a matching or overlapping entry.
// Configuration writes are taken at any time but belong in idle periods.
`include "assert_macros.svh"

module memory_type_range_allocator_top import mtra_pkg::*; #(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // base_address[51:0], region_size[104:52], memory_type[107:105], zero fill
  input  logic [IN_W-1:0]       s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // status[3:0], slot_index[6:4], base_word[70:7], mask_word[134:71], zero fill
  output logic [OUT_W-1:0]      m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int UW    = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (UW > COUNT_W) ? UW : COUNT_W;

  typedef enum logic [1:0] {S_IDLE, S_CHECK, S_SCAN, S_FINISH} state_t;

  state_t state;

  logic               range_support;
  logic [PAB_W-1:0]   phys_bits;
  logic [COUNT_W-1:0] entry_count;
  logic               wc_support;

  logic [ADDR_W-1:0] req_base;
  logic [SIZE_W-1:0] req_size;
  logic [TYPE_W-1:0] req_type;
  logic [SUM_W-1:0]  req_sum;
  logic [SIZE_W-1:0] req_size_m1;

  logic [UW-1:0]     rd_idx;
  logic              p1_v;
  logic [IDX_W-1:0]  p1_idx;
  logic              p2_v;
  logic [IDX_W-1:0]  p2_idx;
  logic              p2_valid_ent;
  logic [ADDR_W-1:0] p2_eb;
  logic [SIZE_W-1:0] p2_es;
  logic              p2_eq_base;
  logic              p2_gt;
  logic              cand_v;
  logic [IDX_W-1:0]  cand_idx;

  status_t           res_status;
  logic [IDX_W-1:0]  res_slot;

  logic [ADDR_W-1:0] pm;
  logic [CMP_W-1:0]  count_ext;
  logic [UW-1:0]     used;
  chk_t              chk;
  entry_t            tbl_rd_data;
  logic              tbl_rd_valid;
  logic              tbl_wr_en;
  entry_t            tbl_wr_data;
  logic              accept;
  logic              issue;
  logic              out_free;
  logic [ADDR_W-1:0] s1_eb;
  logic [SIZE_W-1:0] s1_es;
  logic [SUM_W-1:0]  eb_end;
  logic              st2_match;
  logic              st2_ovl;
  logic              st2_last;
  logic              scan_done;
  status_t           scan_status;
  logic [IDX_W-1:0]  scan_slot;
  logic [ADDR_W-1:0] mask_addr;
  logic [WORD_W-1:0] base_word;
  logic [WORD_W-1:0] mask_word;

  mtra_check u_check (
    .clk           (clk),
    .rst           (rst),
    .start         (accept),
    .base          (s_tdata[ADDR_W-1:0]),
    .size          (s_tdata[ADDR_W+SIZE_W-1:ADDR_W]),
    .mtype         (s_tdata[ADDR_W+SIZE_W+TYPE_W-1:ADDR_W+SIZE_W]),
    .range_support (range_support),
    .wc_support    (wc_support),
    .result        (chk)
  );

  mtra_table #(.MAX_ENTRIES(MAX_ENTRIES)) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rd_idx[IDX_W-1:0]),
    .rd_data  (tbl_rd_data),
    .rd_valid (tbl_rd_valid),
    .wr_en    (tbl_wr_en),
    .wr_addr  (res_slot),
    .wr_data  (tbl_wr_data)
  );

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign pm       = phys_mask(phys_bits);

  // Saturate the entry count to the table depth.
  assign count_ext = CMP_W'(entry_count);
  assign used      = (count_ext > CMP_W'(MAX_ENTRIES)) ? UW'(MAX_ENTRIES) : UW'(count_ext);

  assign issue = (state == S_SCAN) && (rd_idx < used);

  // Decode stage: stored entries decode against the current address mask.
  assign s1_eb = {tbl_rd_data.base_hi, PAGE_W'(0)};
  assign s1_es = SIZE_W'(pm ^ {tbl_rd_data.mask_hi, PAGE_W'(0)}) + SIZE_W'(1);

  // Decision stage.
  assign eb_end    = SUM_W'(p2_eb) + SUM_W'(p2_es);
  assign st2_match = p2_valid_ent && p2_eq_base && (p2_es == req_size);
  assign st2_ovl   = p2_valid_ent && !st2_match &&
                     (p2_gt ? (req_sum > SUM_W'(p2_eb)) : (eb_end > SUM_W'(req_base)));
  assign st2_last  = (UW'(p2_idx) + UW'(1)) == used;

  always_comb begin
    scan_done   = 1'b0;
    scan_status = ST_OK;
    scan_slot   = p2_idx;
    if (p2_v) begin
      if (!p2_valid_ent) begin
        scan_done = st2_last;
      end else if (st2_match) begin
        scan_done = 1'b1;
      end else if (st2_ovl) begin
        scan_done   = 1'b1;
        scan_status = ST_OVERLAP;
      end else if (st2_last) begin
        scan_done   = 1'b1;
        scan_slot   = cand_idx;
        scan_status = cand_v ? ST_OK : ST_NO_SLOT;
      end
    end
  end

  assign mask_addr = pm & ~req_size_m1[ADDR_W-1:0];
  assign base_word = WORD_W'(req_base) | WORD_W'(req_type);
  assign mask_word = WORD_W'(mask_addr) | (WORD_W'(1) << VALID_BIT);

  assign tbl_wr_data.base_hi = req_base[ADDR_W-1:PAGE_W];
  assign tbl_wr_data.mask_hi = mask_addr[ADDR_W-1:PAGE_W];
  // The write lands as the request retires, before the next request is taken.
  assign tbl_wr_en = (state == S_FINISH) && out_free && (res_status == ST_OK);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_tvalid      <= 1'b0;
      p1_v          <= 1'b0;
      p2_v          <= 1'b0;
      cand_v        <= 1'b0;
      rd_idx        <= '0;
      range_support <= 1'b1;
      phys_bits     <= RST_PHYS_BITS;
      entry_count   <= RST_ENTRY_COUNT;
      wc_support    <= 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_index_t'(cfg_addr))
          CFG_RANGE_SUPPORT:  range_support <= cfg_wdata[0];
          CFG_PHYS_ADDR_BITS: phys_bits     <= cfg_wdata[PAB_W-1:0];
          CFG_ENTRY_COUNT:    entry_count   <= cfg_wdata[COUNT_W-1:0];
          CFG_WC_SUPPORT:     wc_support    <= cfg_wdata[0];
          default: ;
        endcase
      end

      // Drop the result once taken, unless a new one replaces it this cycle.
      if (m_tvalid && m_tready && (state != S_FINISH)) begin
        m_tvalid <= 1'b0;
      end

      // Read pipeline: drop in-flight reads once the scan has decided.
      p1_v   <= issue && !scan_done;
      p1_idx <= rd_idx[IDX_W-1:0];
      if (issue) begin
        rd_idx <= rd_idx + UW'(1);
      end
      p2_v         <= p1_v && !scan_done && (state == S_SCAN);
      p2_idx       <= p1_idx;
      p2_valid_ent <= tbl_rd_valid;
      p2_eb        <= s1_eb;
      p2_es        <= s1_es;
      p2_eq_base   <= (s1_eb == req_base);
      p2_gt        <= (s1_eb > req_base);

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req_base <= s_tdata[ADDR_W-1:0];
            req_size <= s_tdata[ADDR_W+SIZE_W-1:ADDR_W];
            req_type <= s_tdata[ADDR_W+SIZE_W+TYPE_W-1:ADDR_W+SIZE_W];
            state    <= S_CHECK;
          end
        end
        S_CHECK: begin
          req_sum     <= SUM_W'(req_base) + SUM_W'(req_size);
          req_size_m1 <= req_size - SIZE_W'(1);
          rd_idx      <= '0;
          cand_v      <= 1'b0;
          if (chk.valid) begin
            if (chk.status != ST_OK) begin
              res_status <= chk.status;
              state      <= S_FINISH;
            end else if (used == '0) begin
              res_status <= ST_NO_SLOT;
              state      <= S_FINISH;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Remember the last invalid entry seen.
          if (p2_v && !p2_valid_ent) begin
            cand_v   <= 1'b1;
            cand_idx <= p2_idx;
          end
          if (scan_done) begin
            res_status <= scan_status;
            res_slot   <= scan_slot;
            state      <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            if (res_status == ST_OK) begin
              m_tdata <= {1'b0, mask_word, base_word, SLOT_W'(res_slot), res_status};
            end else begin
              m_tdata <= {(OUT_W - 4)'(0), res_status};
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_err_payload_zero, (m_tvalid && (m_tdata[3:0] != ST_OK)) |-> (m_tdata[OUT_W-1:4] == '0), "error result with nonzero payload")
  `ASSERT_ALWAYS(a_decode_in_scan, p2_v |-> (state == S_SCAN), "decode stage active outside scan")
  `ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready, "second request taken while busy")
  `ASSERT_NEXT(a_finish_emits, (state == S_FINISH) && (!m_tvalid || m_tready), m_tvalid, "finished request produced no result")

endmodule
